// File: rtl/core/custody_table_engine_unit_assert.svh
// Assertion macros shared by the custody table checker.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef CUSTODY_TABLE_ENGINE_UNIT_ASSERT_SVH
`define CUSTODY_TABLE_ENGINE_UNIT_ASSERT_SVH
// Same-cycle implication, disabled in reset
`define CTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset
`define CTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Next-cycle implication that also holds across reset
`define CTU_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/core/ctu_pkg.sv
// Shared types and constants of the custody table engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctu_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [31:0] MAX_SIZE_RESET = 32'd65536;
  localparam logic [3:0] VERSION_V6 = 4'd6;

  typedef enum logic [1:0] {
    REQ_ACCEPT  = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_FIND    = 2'd2,
    REQ_QUERY   = 2'd3
  } req_kind_t;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NON_V6    = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_HELD      = 3'd3;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd4;
  localparam logic [2:0] STAT_NON_SINGLE = 3'd5;
  localparam logic [2:0] STAT_REDUNDANT = 3'd6;

  // One table row
  typedef struct packed {
    logic [15:0] handle;
    logic [63:0] timestamp;
    logic [15:0] sequence_nr;
    logic [31:0] source;
    logic        fragment;
    logic [31:0] offset;
    logic [31:0] length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Classified request as queued between front and back
  typedef struct packed {
    req_kind_t kind;
    entry_t    key;
    logic      other_retention;
    logic      too_large;
    logic      non_single;
    logic      is_v6;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_RESP
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/core/custody_table_engine_unit.sv
// Custody table engine: one request in, one result beat out.
// Flow: the held rows are scanned, one RAM read per row, and the request is decided;
// a release that finds its handle also compacts the table before its result.
// Throughput: one request at a time; a 2-deep queue takes new beats meanwhile.
// Reset: synchronous rst empties the table and sets the size limit to 65536.
`timescale 1ns / 1ps
`default_nettype none
module custody_table_engine_unit #(
  parameter int TABLE_DEPTH = ctu_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] bundle_handle,
  input  wire logic [63:0] create_time,
  input  wire logic [15:0] seq_num,
  input  wire logic [31:0] source_id,
  input  wire logic        is_fragment,
  input  wire logic [31:0] frag_offset,
  input  wire logic [31:0] payload_length,
  input  wire logic [31:0] serialized_size,
  input  wire logic [3:0]  bp_version,
  input  wire logic        singleton_dest,
  input  wire logic        other_retention,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             found,
  output logic [15:0]      match_handle,
  output logic             drop_bundle,
  output logic             custodian_set
);

  logic          q_valid, q_pop;
  ctu_pkg::req_t q_data;

  ctu_front u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .req_type           (req_type),
    .bundle_handle      (bundle_handle),
    .create_time        (create_time),
    .seq_num            (seq_num),
    .source_id          (source_id),
    .is_fragment        (is_fragment),
    .frag_offset        (frag_offset),
    .payload_length     (payload_length),
    .serialized_size    (serialized_size),
    .bp_version         (bp_version),
    .singleton_dest     (singleton_dest),
    .other_retention    (other_retention),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop)
  );

  ctu_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found         (found),
    .match_handle  (match_handle),
    .drop_bundle   (drop_bundle),
    .custodian_set (custodian_set)
  );

endmodule
`default_nettype wire

// File: rtl/core/ctu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ctu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ctu_front.sv
// Front end: accepts request beats, classifies them and queues them.
// Holds the size limit register. Depends on ctu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctu_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          req_type,
  input  wire logic [15:0]         bundle_handle,
  input  wire logic [63:0]         create_time,
  input  wire logic [15:0]         seq_num,
  input  wire logic [31:0]         source_id,
  input  wire logic                is_fragment,
  input  wire logic [31:0]         frag_offset,
  input  wire logic [31:0]         payload_length,
  input  wire logic [31:0]         serialized_size,
  input  wire logic [3:0]          bp_version,
  input  wire logic                singleton_dest,
  input  wire logic                other_retention,
  output logic                     q_valid,
  output ctu_pkg::req_t            q_data,
  input  wire logic                q_pop
);

  logic [31:0]    max_size;
  ctu_pkg::req_t  slot [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     fill;
  ctu_pkg::req_t  cls;
  logic           push;

  // Classify the incoming beat
  always_comb begin
    cls.kind              = ctu_pkg::req_kind_t'(req_type);
    cls.key.handle        = bundle_handle;
    cls.key.timestamp     = create_time;
    cls.key.sequence_nr   = seq_num;
    cls.key.source        = source_id;
    cls.key.fragment      = is_fragment;
    cls.key.offset        = frag_offset;
    cls.key.length        = payload_length;
    cls.other_retention   = other_retention;
    cls.too_large         = serialized_size > max_size;
    cls.is_v6             = bp_version == ctu_pkg::VERSION_V6;
    cls.non_single        = cls.is_v6 && !singleton_dest;
  end

  assign in_stall = fill[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = fill != 2'd0;
  assign q_data   = slot[rd_ptr];

  // Hold the size limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= ctu_pkg::MAX_SIZE_RESET;
    end else if (cfg_write) begin
      max_size <= cfg_data;
    end
  end

  // Two-slot queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ctu_back.sv
// Back end: scans the table, decides, appends or compacts, and drives results.
// Depends on ctu_pkg and ctu_ram.
`timescale 1ns / 1ps
`default_nettype none
module ctu_back #(
  parameter int TABLE_DEPTH = ctu_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire ctu_pkg::req_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          status,
  output logic                found,
  output logic [15:0]         match_handle,
  output logic                drop_bundle,
  output logic                custodian_set
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  ctu_pkg::back_state_t state, state_next;
  ctu_pkg::req_t  req, req_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  idx, idx_next;
  logic           pend, pend_next;
  logic [CW-1:0]  pend_idx, pend_idx_next;
  logic           hit_h, hit_h_next, hit_k, hit_k_next;
  logic [CW-1:0]  h_pos, h_pos_next;
  logic [15:0]    k_handle, k_handle_next;
  logic [2:0]     r_status, r_status_next;
  logic           r_found, r_found_next, r_drop, r_drop_next, r_cust, r_cust_next;
  logic           out_valid_next, load;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  ctu_pkg::entry_t     rd_entry, wr_entry;
  logic [ctu_pkg::ENTRY_W-1:0] rd_bits;

  logic scan_more, key_eq, handle_eq;

  ctu_ram #(
    .WIDTH (ctu_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign rd_entry  = ctu_pkg::entry_t'(rd_bits);
  assign scan_more = idx < count;
  assign handle_eq = rd_entry.handle == req.key.handle;
  assign key_eq    = rd_entry.timestamp == req.key.timestamp
                  && rd_entry.sequence_nr == req.key.sequence_nr
                  && rd_entry.source == req.key.source
                  && (!rd_entry.fragment
                      || (rd_entry.offset == req.key.offset
                          && rd_entry.length == req.key.length));
  assign load = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ctu_pkg::ST_IDLE:   if (q_valid) state_next = ctu_pkg::ST_SCAN;
      ctu_pkg::ST_SCAN:   if (!scan_more && !pend) state_next = ctu_pkg::ST_DECIDE;
      ctu_pkg::ST_DECIDE: begin
        if (req.kind == ctu_pkg::REQ_RELEASE && hit_h) begin
          state_next = ctu_pkg::ST_SHIFT;
        end else begin
          state_next = ctu_pkg::ST_RESP;
        end
      end
      ctu_pkg::ST_SHIFT:  if (!scan_more && !pend) state_next = ctu_pkg::ST_RESP;
      ctu_pkg::ST_RESP:   if (load) state_next = ctu_pkg::ST_IDLE;
      default:            state_next = ctu_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    q_pop          = 1'b0;
    req_next       = req;
    count_next     = count;
    idx_next       = idx;
    pend_next      = 1'b0;
    pend_idx_next  = pend_idx;
    hit_h_next     = hit_h;
    hit_k_next     = hit_k;
    h_pos_next     = h_pos;
    k_handle_next  = k_handle;
    r_status_next  = r_status;
    r_found_next   = r_found;
    r_drop_next    = r_drop;
    r_cust_next    = r_cust;
    out_valid_next = out_valid && out_stall;
    rd_en          = 1'b0;
    rd_addr        = idx[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = AW'(pend_idx - 1'b1);
    wr_entry       = rd_entry;
    case (state)
      ctu_pkg::ST_IDLE: begin
        q_pop      = q_valid;
        req_next   = q_data;
        idx_next   = '0;
        hit_h_next = 1'b0;
        hit_k_next = 1'b0;
      end
      ctu_pkg::ST_SCAN: begin
        // Issue one read a cycle, compare the previous read
        if (scan_more) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = idx;
          idx_next      = idx + 1'b1;
        end
        if (pend) begin
          if (handle_eq && !hit_h) begin
            hit_h_next = 1'b1;
            h_pos_next = pend_idx;
          end
          if (key_eq && !hit_k) begin
            hit_k_next    = 1'b1;
            k_handle_next = rd_entry.handle;
          end
        end
      end
      ctu_pkg::ST_DECIDE: begin
        r_status_next = ctu_pkg::STAT_OK;
        r_found_next  = 1'b0;
        r_drop_next   = 1'b0;
        r_cust_next   = 1'b0;
        k_handle_next = '0;
        case (req.kind)
          ctu_pkg::REQ_ACCEPT: begin
            if (count >= DEPTH_C) begin
              r_status_next = ctu_pkg::STAT_FULL;
            end else if (hit_h) begin
              r_status_next = ctu_pkg::STAT_HELD;
            end else if (req.too_large) begin
              r_status_next = ctu_pkg::STAT_TOO_LARGE;
            end else if (req.non_single) begin
              r_status_next = ctu_pkg::STAT_NON_SINGLE;
            end else if (hit_k) begin
              r_status_next = ctu_pkg::STAT_REDUNDANT;
            end else begin
              // Append at the end of the table
              wr_en      = 1'b1;
              wr_addr    = count[AW-1:0];
              wr_entry   = req.key;
              count_next = count + 1'b1;
              if (req.is_v6) begin
                r_cust_next = 1'b1;
              end else begin
                r_status_next = ctu_pkg::STAT_NON_V6;
              end
            end
          end
          ctu_pkg::REQ_RELEASE: begin
            r_found_next = hit_h;
            r_drop_next  = hit_h && !req.other_retention;
            idx_next     = h_pos + 1'b1;
          end
          ctu_pkg::REQ_FIND: begin
            r_found_next  = hit_k;
            k_handle_next = hit_k ? k_handle : 16'd0;
          end
          ctu_pkg::REQ_QUERY: r_found_next = hit_h;
          default: r_found_next = 1'b0;
        endcase
      end
      ctu_pkg::ST_SHIFT: begin
        // Move each later row down by one to close the gap
        if (scan_more) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = idx;
          idx_next      = idx + 1'b1;
        end
        if (pend) begin
          wr_en = 1'b1;
        end
        if (!scan_more && !pend) begin
          count_next = count - 1'b1;
        end
      end
      ctu_pkg::ST_RESP: begin
        if (load) begin
          out_valid_next = 1'b1;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ctu_pkg::ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
    hit_h    <= hit_h_next;
    hit_k    <= hit_k_next;
    h_pos    <= h_pos_next;
    k_handle <= k_handle_next;
    r_status <= r_status_next;
    r_found  <= r_found_next;
    r_drop   <= r_drop_next;
    r_cust   <= r_cust_next;
    if (state == ctu_pkg::ST_RESP && load) begin
      status        <= r_status;
      found         <= r_found;
      match_handle  <= k_handle;
      drop_bundle   <= r_drop;
      custodian_set <= r_cust;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ctu_checker.sv
// Port-level checks of the custody table engine, bound to the top level.
// Depends on ctu_pkg and custody_table_engine_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "custody_table_engine_unit_assert.svh"
module ctu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic        found,
  input wire logic [15:0] match_handle,
  input wire logic        drop_bundle,
  input wire logic        custodian_set
);

  // Hold a stalled result beat
  `CTU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(match_handle), "stalled result beat changed")
  // A miss never carries a handle
  `CTU_ASSERT_NOW(a_no_handle, out_valid && !found, match_handle == 16'd0, "handle without a match")
  // Custody taken only on a clean accept
  `CTU_ASSERT_NOW(a_cust_ok, out_valid && custodian_set, status == ctu_pkg::STAT_OK && !found && !drop_bundle, "custody flag on a non-accept result")
  // Drop only for a found release
  `CTU_ASSERT_NOW(a_drop_found, out_valid && drop_bundle, found && status == ctu_pkg::STAT_OK, "drop without a found handle")
  // No result right after reset
  `CTU_ASSERT_RST(a_reset_quiet, rst, !out_valid, "result beat after reset")

endmodule

bind custody_table_engine_unit ctu_checker u_ctu_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for the custody table engine: directed and random requests.
// Depends on ctu_pkg and custody_table_engine_unit.
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH = ctu_pkg::TABLE_DEPTH_DEF;

  typedef struct {
    logic [2:0]  status;
    logic        found;
    logic [15:0] match_handle;
    logic        drop_bundle;
    logic        custodian_set;
  } custody_result_t;

  typedef struct {
    ctu_pkg::req_kind_t kind;
    logic [15:0] handle;
    logic [63:0] ts;
    logic [15:0] seq;
    logic [31:0] src;
    logic        frag;
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] size;
    logic [3:0]  ver;
    logic        single;
    logic        other;
  } custody_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [15:0] bundle_handle = '0;
  logic [63:0] create_time = '0;
  logic [15:0] seq_num = '0;
  logic [31:0] source_id = '0;
  logic is_fragment = 1'b0;
  logic [31:0] frag_offset = '0;
  logic [31:0] payload_length = '0;
  logic [31:0] serialized_size = '0;
  logic [3:0] bp_version = '0;
  logic singleton_dest = 1'b0;
  logic other_retention = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic found;
  logic [15:0] match_handle;
  logic drop_bundle;
  logic custodian_set;

  // Predictor copy of the table
  ctu_pkg::entry_t held_rows[DEPTH];
  int          held_count;
  logic [31:0] size_limit;
  custody_result_t pending_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count;
  int sent_count;
  int checked_count;

  always #5 clk = ~clk;

  custody_table_engine_unit i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .bundle_handle(bundle_handle), .create_time(create_time),
    .seq_num(seq_num), .source_id(source_id),
    .is_fragment(is_fragment), .frag_offset(frag_offset),
    .payload_length(payload_length), .serialized_size(serialized_size),
    .bp_version(bp_version), .singleton_dest(singleton_dest),
    .other_retention(other_retention), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .found(found),
    .match_handle(match_handle), .drop_bundle(drop_bundle),
    .custodian_set(custodian_set)
  );

  function automatic int find_handle(logic [15:0] h);
    for (int i = 0; i < held_count; i++)
      if (held_rows[i].handle == h) return i;
    return -1;
  endfunction

  function automatic int find_key(custody_req_t r);
    for (int i = 0; i < held_count; i++)
      if (held_rows[i].timestamp == r.ts && held_rows[i].sequence_nr == r.seq &&
          held_rows[i].source == r.src &&
          (!held_rows[i].fragment ||
           (held_rows[i].offset == r.off && held_rows[i].length == r.len)))
        return i;
    return -1;
  endfunction

  // Apply one request to the table and compute its result beat
  function automatic custody_result_t apply_custody_request(custody_req_t r);
    custody_result_t res;
    int idx;
    res = '{ctu_pkg::STAT_OK, 1'b0, 16'd0, 1'b0, 1'b0};
    case (r.kind)
      ctu_pkg::REQ_ACCEPT: begin
        if (held_count >= DEPTH) res.status = ctu_pkg::STAT_FULL;
        else if (find_handle(r.handle) >= 0) res.status = ctu_pkg::STAT_HELD;
        else if (r.size > size_limit) res.status = ctu_pkg::STAT_TOO_LARGE;
        else if (r.ver == ctu_pkg::VERSION_V6 && !r.single)
          res.status = ctu_pkg::STAT_NON_SINGLE;
        else if (find_key(r) >= 0) res.status = ctu_pkg::STAT_REDUNDANT;
        else begin
          held_rows[held_count] = '{r.handle, r.ts, r.seq, r.src, r.frag, r.off, r.len};
          held_count++;
          if (r.ver == ctu_pkg::VERSION_V6) res.custodian_set = 1'b1;
          else res.status = ctu_pkg::STAT_NON_V6;
        end
      end
      ctu_pkg::REQ_RELEASE: begin
        idx = find_handle(r.handle);
        if (idx >= 0) begin
          for (int i = idx; i + 1 < held_count; i++) held_rows[i] = held_rows[i + 1];
          held_count--;
          res.found = 1'b1;
          res.drop_bundle = !r.other;
        end
      end
      ctu_pkg::REQ_FIND: begin
        idx = find_key(r);
        if (idx >= 0) begin
          res.found = 1'b1;
          res.match_handle = held_rows[idx].handle;
        end
      end
      default: res.found = find_handle(r.handle) >= 0;
    endcase
    return res;
  endfunction

  // Drive one beat, hold it until accepted, then record the expectation
  task automatic send_request(custody_req_t r);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    bundle_handle <= r.handle;
    create_time <= r.ts;
    seq_num <= r.seq;
    source_id <= r.src;
    is_fragment <= r.frag;
    frag_offset <= r.off;
    payload_length <= r.len;
    serialized_size <= r.size;
    bp_version <= r.ver;
    singleton_dest <= r.single;
    other_retention <= r.other;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_custody_request(r));
    sent_count++;
  endtask

  // Random receiver stall, updated every edge
  always @(posedge clk)
    out_stall <= receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct;

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    custody_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        checked_count++;
        if (status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, status);
          error_count++;
        end
        if (found !== exp_res.found) begin
          $error("found expected %0d actual %0d", exp_res.found, found);
          error_count++;
        end
        if (match_handle !== exp_res.match_handle) begin
          $error("match_handle expected %0h actual %0h", exp_res.match_handle, match_handle);
          error_count++;
        end
        if (drop_bundle !== exp_res.drop_bundle) begin
          $error("drop_bundle expected %0d actual %0d", exp_res.drop_bundle, drop_bundle);
          error_count++;
        end
        if (custodian_set !== exp_res.custodian_set) begin
          $error("custodian_set expected %0d actual %0d", exp_res.custodian_set,
                 custodian_set);
          error_count++;
        end
      end
    end
  end

  // Drop the request valid and wait for every result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
  endtask

  // Write the size limit while idle
  task automatic write_size_limit(logic [31:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    size_limit = value;
  endtask

  // Build a request; small key pools make duplicates and matches common
  function automatic custody_req_t make_request(ctu_pkg::req_kind_t kind, logic [15:0] h);
    custody_req_t r;
    r.kind = kind;
    r.handle = h;
    r.ts = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3));
    r.seq = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    r.src = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(2));
    r.frag = 1'($urandom_range(1));
    r.off = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(2));
    r.len = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(2));
    r.size = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(70000));
    r.ver = ($urandom_range(3) == 0) ? 4'($urandom)
          : ($urandom_range(1) ? ctu_pkg::VERSION_V6 : 4'd7);
    r.single = ($urandom_range(4) != 0);
    r.other = 1'($urandom_range(1));
    return r;
  endfunction

  // Pick a handle that is often held, sometimes fresh
  function automatic logic [15:0] pick_handle();
    if (held_count > 0 && $urandom_range(2) != 0)
      return held_rows[$urandom_range(held_count - 1)].handle;
    return ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(40));
  endfunction

  task automatic test_directed();
    custody_req_t r;
    // Fill to full, mixing versions and field extremes
    for (int i = 0; i < DEPTH; i++) begin
      r = make_request(ctu_pkg::REQ_ACCEPT, 16'(i == 0 ? 16'hFFFF : i));
      r.ts = (i == 1) ? '1 : 64'(i);
      r.src = (i == 2) ? '1 : 32'(i);
      r.seq = (i == 3) ? '1 : 16'(i);
      r.off = (i == 4) ? '1 : 32'(0);
      r.len = (i == 5) ? '1 : 32'(0);
      r.frag = i[0];
      r.size = (i == 6) ? ctu_pkg::MAX_SIZE_RESET : 32'd100;
      r.ver = (i % 3 == 0) ? ctu_pkg::VERSION_V6 : ((i == 7) ? 4'hF : 4'd7);
      r.single = 1'b1;
      send_request(r);
    end
    r = make_request(ctu_pkg::REQ_ACCEPT, 16'd500);
    send_request(r);                                  // table full
    r = make_request(ctu_pkg::REQ_FIND, 16'd0);
    r.ts = '1; r.seq = 16'd1; r.src = 32'd1; r.off = '1; r.len = '1;
    send_request(r);                                  // find, fragment offset and length differ
    r = make_request(ctu_pkg::REQ_QUERY, 16'hFFFF);
    send_request(r);
    r = make_request(ctu_pkg::REQ_RELEASE, 16'd3);
    r.other = 1'b0;
    send_request(r);                                  // release with drop
    r.other = 1'b1;
    send_request(r);                                  // release of absent handle
    r = make_request(ctu_pkg::REQ_ACCEPT, 16'd4);
    send_request(r);                                  // already held
    r = make_request(ctu_pkg::REQ_ACCEPT, 16'd600);
    r.size = ctu_pkg::MAX_SIZE_RESET + 1;
    send_request(r);                                  // too large
    r.size = 32'd0; r.ver = ctu_pkg::VERSION_V6; r.single = 1'b0;
    send_request(r);                                  // non-singleton
    r.single = 1'b1; r.ts = 64'd0; r.seq = 16'd0; r.src = 32'd0; r.off = 32'd0;
    r.len = 32'd0;
    send_request(r);                                  // redundant with row 0
    r = make_request(ctu_pkg::REQ_QUERY, 16'd3);
    send_request(r);
  endtask

  task automatic test_random(int count);
    custody_req_t r;
    ctu_pkg::req_kind_t kind;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = ctu_pkg::REQ_ACCEPT;
      else if (pick < 65) kind = ctu_pkg::REQ_RELEASE;
      else if (pick < 85) kind = ctu_pkg::REQ_FIND;
      else kind = ctu_pkg::REQ_QUERY;
      r = make_request(kind, pick_handle());
      // Aim finds at held keys most of the time
      if (kind == ctu_pkg::REQ_FIND && held_count > 0 && $urandom_range(2) != 0) begin
        pick = $urandom_range(held_count - 1);
        r.ts = held_rows[pick].timestamp;
        r.seq = held_rows[pick].sequence_nr;
        r.src = held_rows[pick].source;
        if ($urandom_range(3) != 0) begin
          r.off = held_rows[pick].offset;
          r.len = held_rows[pick].length;
        end
      end
      send_request(r);
    end
  endtask

  initial begin
    held_count = 0;
    size_limit = ctu_pkg::MAX_SIZE_RESET;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    write_size_limit(32'd0);
    test_random(150);
    write_size_limit(32'hFFFF_FFFF);
    sender_idle_pct = 61;
    test_random(450);
    write_size_limit(32'd40000);
    sender_idle_pct = 0;
    receiver_stall_pct = 61;
    test_random(450);
    write_size_limit(ctu_pkg::MAX_SIZE_RESET);
    sender_idle_pct = 33;
    receiver_stall_pct = 33;
    test_random(450);
    write_size_limit(32'hFFFF_FFFF);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random(330);
    drain_results();

    $display("Sent %0d requests, checked %0d result beats over five size limits",
             sent_count, checked_count);
    $display("and four handshake pressure phases");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
